// ===== rtl/skle_pkg.sv =====
// Shared types and codes for the sorted key list engine.
// Used by skle_cell and sorted_key_list_engine_unit; depends on nothing else.
package skle_pkg;

    // Request codes carried in the req_type field.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Status codes carried in the status field.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Input word.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] flight_id;
        logic [5:0]  depart_minute;
        logic [31:0] flight_data;
    } t_skle_in;

    // Output word.
    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  found_minute;
        logic [31:0] found_data;
    } t_skle_out;

    // One stored record.
    typedef struct packed {
        logic [15:0] id;
        logic [5:0]  key;
        logic [31:0] data;
    } t_skle_rec;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic cmp;  // compare the held record against the request
        logic ins;  // apply an accepted insert
        logic rm;   // apply a remove that found its id
    } t_skle_cmd;

endpackage

// ===== rtl/skle_cell.sv =====
// One cell of the sorted record chain: holds a record, a valid bit and compare flags.
// Depends on skle_pkg; instantiated once per list slot by sorted_key_list_engine_unit.
module skle_cell
    import skle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_skle_cmd i_cmd,
    input  t_skle_rec i_new,
    input  t_skle_rec i_left_rec,
    input  logic      i_left_vld,
    input  logic      i_left_le,
    input  t_skle_rec i_right_rec,
    input  logic      i_right_vld,
    input  logic      i_hit_before,
    output t_skle_rec o_rec,
    output logic      o_vld,
    output logic      o_le,
    output logic      o_hit
);

    t_skle_rec r_rec;
    t_skle_rec n_rec;
    logic      r_vld;
    logic      n_vld;
    logic      r_le;
    logic      r_hit;

    // Next record: keep, take the new record, shift in from the left or from the right.
    always_comb begin
        n_rec = r_rec;
        n_vld = r_vld;
        if (i_cmd.ins && !r_le) begin
            if (i_left_le) begin
                n_rec = i_new;
                n_vld = 1'b1;
            end else begin
                n_rec = i_left_rec;
                n_vld = i_left_vld;
            end
        end else if (i_cmd.rm && (i_hit_before || r_hit)) begin
            n_rec = i_right_rec;
            n_vld = i_right_vld;
        end
    end

    // The valid bit is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Record and compare flags need no reset.
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
        if (i_cmd.cmp) begin
            r_le  <= r_vld && (r_rec.key <= i_new.key);
            r_hit <= r_vld && (r_rec.id == i_new.id);
        end
    end

    assign o_rec = r_rec;
    assign o_vld = r_vld;
    assign o_le  = r_le;
    assign o_hit = r_hit;

endmodule

// ===== rtl/sorted_key_list_engine_unit.sv =====
// Top level of the sorted key list engine: controller, cell chain and result register.
// Depends on skle_pkg and skle_cell.

// Keeps up to DEPTH records (id, key, payload) in ascending key order, equal keys in
// arrival order, in a row of cells that each hold one record. Every request goes through a
// compare state, in which all cells compare their record with the request at once, and then
// an apply state, in which each cell keeps its record, takes the new one or takes a
// neighbour's, and the result word is loaded into the output register. A new word is
// accepted in the apply state of the previous one; the apply state waits while the output
// register still holds a result not yet taken. An insert into a full list, and a remove
// or lookup of an absent id, leave the list as it is.
module sorted_key_list_engine_unit
    import skle_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_skle_in  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_skle_out o_out_word
);

    localparam int LVL = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_skle_in  r_req;
    t_skle_out r_out;
    t_skle_out n_out;
    logic      r_out_vld;

    t_skle_cmd  w_cmd;
    t_skle_rec  w_new;
    t_skle_rec  w_rec [DEPTH];
    logic [DEPTH-1:0] w_vld;
    logic [DEPTH-1:0] w_le;
    logic [DEPTH-1:0] w_hit;
    logic [DEPTH-1:0] w_pre;
    logic [DEPTH-1:0] w_pre_tmp;
    logic [DEPTH-1:0] w_hit_before;
    logic [DEPTH-1:0] w_first;
    logic             w_any_hit;
    logic             w_full;
    logic             w_commit;
    logic             w_accept;
    t_skle_rec        w_found;

    // Handshake and sequencing.
    assign w_commit   = (r_state == S_APPLY) && (!r_out_vld || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) || w_commit;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_commit) begin
                    n_state = w_accept ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Request and result words.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_word;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    // Broadcast record and command for the cells.
    assign w_new.id   = r_req.flight_id;
    assign w_new.key  = r_req.depart_minute;
    assign w_new.data = r_req.flight_data;

    assign w_full    = w_vld[DEPTH-1];
    assign w_cmd.cmp = (r_state == S_CMP);
    assign w_cmd.ins = w_commit && (r_req.req_type == REQ_INSERT) && !w_full;
    assign w_cmd.rm  = w_commit && (r_req.req_type == REQ_REMOVE) && w_any_hit;

    // Parallel prefix OR of the hit flags marks every cell at or after the first match.
    always_comb begin
        w_pre = w_hit;
        for (int lv = 0; lv < LVL; lv++) begin
            w_pre_tmp = w_pre;
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << lv)) begin
                    w_pre[i] = w_pre_tmp[i] | w_pre_tmp[i - (1 << lv)];
                end
            end
        end
    end

    assign w_hit_before = {w_pre[DEPTH-2:0], 1'b0};
    assign w_any_hit    = w_pre[DEPTH-1];
    assign w_first      = w_hit & ~w_hit_before;

    // Select the first matching record for a lookup.
    always_comb begin
        w_found = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first[i]) begin
                w_found = w_found | w_rec[i];
            end
        end
    end

    // Result word.
    always_comb begin
        n_out = '0;
        case (r_req.req_type)
            REQ_INSERT: begin
                n_out.status = w_full ? ST_FULL : ST_OK;
            end
            REQ_REMOVE: begin
                n_out.status = w_any_hit ? ST_OK : ST_NOT_FOUND;
            end
            REQ_LOOKUP: begin
                if (w_any_hit) begin
                    n_out.status       = ST_OK;
                    n_out.found_minute = w_found.key;
                    n_out.found_data   = w_found.data;
                end else begin
                    n_out.status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // The chain of cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_skle_rec w_left_rec;
        logic      w_left_vld;
        logic      w_left_le;
        t_skle_rec w_right_rec;
        logic      w_right_vld;

        if (g == 0) begin : g_head
            assign w_left_rec = '0;
            assign w_left_vld = 1'b0;
            assign w_left_le  = 1'b1;
        end else begin : g_body
            assign w_left_rec = w_rec[g-1];
            assign w_left_vld = w_vld[g-1];
            assign w_left_le  = w_le[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_rec = '0;
            assign w_right_vld = 1'b0;
        end else begin : g_inner
            assign w_right_rec = w_rec[g+1];
            assign w_right_vld = w_vld[g+1];
        end

        skle_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_new        (w_new),
            .i_left_rec   (w_left_rec),
            .i_left_vld   (w_left_vld),
            .i_left_le    (w_left_le),
            .i_right_rec  (w_right_rec),
            .i_right_vld  (w_right_vld),
            .i_hit_before (w_hit_before[g]),
            .o_rec        (w_rec[g]),
            .o_vld        (w_vld[g]),
            .o_le         (w_le[g]),
            .o_hit        (w_hit[g])
        );
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // Checks on the chain and the controller.
    logic [DEPTH:0] w_vld_inc;
    assign w_vld_inc = {1'b0, w_vld} + (DEPTH + 1)'(1);

    a_vld_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_vld_inc))
        else $error("Valid cells do not form a prefix of the chain.");

    a_first_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> $onehot0(w_first))
        else $error("More than one first match in the chain.");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> ($countones(w_vld) == $past($countones(w_vld)) + 1))
        else $error("Insert did not add exactly one record.");

    a_rm_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rm |=> ($countones(w_vld) + 1 == $past($countones(w_vld))))
        else $error("Remove did not drop exactly one record.");

endmodule

// ===== tb/sorted_key_list_engine_unit_tb.sv =====
// Self-checking testbench for the sorted key list engine (sorted_key_list_engine_unit).
// Depends on skle_pkg for the word types and codes; holds its own model of the list.
// Directed words, then three phases of random words under changing flow control.
module sorted_key_list_engine_unit_tb
    import skle_pkg::*;
();

    localparam int LIST_DEPTH = 16;
    localparam int HOLD_CYCLES = 400;

    // Selector code with no request behind it.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Model of the schedule list plus the queue of replies it predicts.
    class schedule_board;
        t_skle_rec entries[$];
        t_skle_out pending_replies[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction

        // Index of the first record carrying this id, or -1.
        function int first_with_id(logic [15:0] id);
            foreach (entries[i]) begin
                if (entries[i].id == id) return i;
            end
            return -1;
        endfunction

        // Apply an accepted request to the list and queue the reply it gives.
        function void take_request(t_skle_in w);
            t_skle_out reply;
            t_skle_rec rec;
            int        pos;
            int        hit;
            reply = '0;
            case (w.req_type)
                REQ_INSERT: begin
                    if (entries.size() >= LIST_DEPTH) begin
                        reply.status = ST_FULL;
                    end else begin
                        // New record goes after every key that is equal or smaller.
                        pos = 0;
                        while (pos < entries.size() && entries[pos].key <= w.depart_minute)
                            pos++;
                        rec.id   = w.flight_id;
                        rec.key  = w.depart_minute;
                        rec.data = w.flight_data;
                        entries.insert(pos, rec);
                    end
                end
                REQ_REMOVE: begin
                    hit = first_with_id(w.flight_id);
                    if (hit < 0) reply.status = ST_NOT_FOUND;
                    else entries.delete(hit);
                end
                REQ_LOOKUP: begin
                    hit = first_with_id(w.flight_id);
                    if (hit < 0) begin
                        reply.status = ST_NOT_FOUND;
                    end else begin
                        reply.found_minute = entries[hit].key;
                        reply.found_data   = entries[hit].data;
                    end
                end
                default: begin
                    // The spare selector code is ignored and answers ok with zeros.
                end
            endcase
            pending_replies.push_back(reply);
        endfunction

        // Compare a delivered word with the oldest predicted reply.
        function void check_reply(t_skle_out got);
            t_skle_out want;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected word status=%0d minute=%0d data=%h",
                             got.status, got.found_minute, got.found_data);
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.found_minute !== want.found_minute ||
                got.found_data !== want.found_data) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: expected status=%0d minute=%0d data=%h",
                             want.status, want.found_minute, want.found_data);
                    $display("       actual   status=%0d minute=%0d data=%h",
                             got.status, got.found_minute, got.found_data);
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_skle_in  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_skle_out o_out_word;

    schedule_board board;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        insert_pct;
    bit        hold_armed;

    sorted_key_list_engine_unit #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    // Free-running clock.
    always #5 i_clk = ~i_clk;

    // Overall time limit in case the block hangs.
    initial begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Offer one word after an optional random gap and wait until it is taken.
    task automatic send_word(input t_skle_in w);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        board.take_request(w);
    endtask

    task automatic send_request(input logic [1:0] req, input logic [15:0] id,
                                input logic [5:0] minute, input logic [31:0] data);
        t_skle_in w;
        w.req_type      = req;
        w.flight_id     = id;
        w.depart_minute = minute;
        w.flight_data   = data;
        send_word(w);
    endtask

    // Random request, mostly aimed at ids that are in the list or a small pool.
    task automatic send_random_request();
        logic [1:0]  req;
        logic [15:0] id;
        logic [5:0]  minute;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) req = REQ_SPARE;
        else if (pick < 4 + insert_pct) req = REQ_INSERT;
        else if (pick < 4 + insert_pct + (96 - insert_pct) / 2) req = REQ_REMOVE;
        else req = REQ_LOOKUP;
        if (req != REQ_INSERT && board.entries.size() > 0 && $urandom_range(0, 99) < 60)
            id = board.entries[$urandom_range(0, board.entries.size() - 1)].id;
        else if ($urandom_range(0, 4) != 0)
            id = 16'($urandom_range(0, 23));
        else
            id = 16'($urandom);
        // A narrow key range now and then makes plenty of equal keys.
        if ($urandom_range(0, 3) == 0) minute = 6'($urandom_range(0, 3));
        else minute = 6'($urandom_range(0, 63));
        send_request(req, id, minute, $urandom);
    endtask

    // Receiver flow control, with one long hold-off at the start of the last phase.
    initial begin
        int held;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (hold_armed && held < HOLD_CYCLES) begin
                held++;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Every word delivered is checked against the model.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_reply(o_out_word);
    end

    // Main sequence.
    initial begin
        int n;
        board       = new();
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_ready = 1'b0;
        hold_armed  = 1'b0;
        tx_idle_pct = 31;
        rx_idle_pct = 87;
        insert_pct  = 50;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty list: misses on lookup and remove, and the spare selector code.
        send_request(REQ_LOOKUP, 16'h0000, 6'd0, 32'h0);
        send_request(REQ_REMOVE, 16'hFFFF, 6'd63, 32'hFFFF_FFFF);
        send_request(REQ_SPARE, 16'hFFFF, 6'h3F, 32'hFFFF_FFFF);

        // Fill the list with extreme fields, equal keys and a duplicate id.
        send_request(REQ_INSERT, 16'h0000, 6'd63, 32'h0000_0000);
        send_request(REQ_INSERT, 16'hFFFF, 6'd0, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 16'h0001, 6'd30, 32'hA5A5_0001);
        send_request(REQ_INSERT, 16'h0002, 6'd30, 32'hA5A5_0002);
        send_request(REQ_INSERT, 16'h0001, 6'd30, 32'hA5A5_0003);
        for (n = 0; n < 11; n++)
            send_request(REQ_INSERT, 16'h0100 + 16'(n), 6'((n * 6) % 64), $urandom);

        // The list is full now, so this insert is refused.
        send_request(REQ_INSERT, 16'h5555, 6'd10, 32'h1234_5678);

        // Duplicate ids resolve to the first in list order; then an absent id.
        send_request(REQ_LOOKUP, 16'h0001, 6'd0, 32'h0);
        send_request(REQ_REMOVE, 16'h0001, 6'd0, 32'h0);
        send_request(REQ_LOOKUP, 16'h0001, 6'd0, 32'h0);
        send_request(REQ_REMOVE, 16'h1234, 6'd0, 32'h0);
        send_request(REQ_LOOKUP, 16'hFFFF, 6'd0, 32'h0);

        // Phase one: slow receiver.
        for (n = 0; n < 540; n++) send_random_request();

        // Phase two: slow sender, list tends to drain.
        tx_idle_pct = 87;
        rx_idle_pct = 31;
        insert_pct  = 28;
        for (n = 0; n < 540; n++) send_random_request();

        // Phase three: no idling, after a long receiver hold-off that backs up the block.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        insert_pct  = 42;
        hold_armed  = 1'b1;
        for (n = 0; n < 560; n++) send_random_request();

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain, then keep watching for any stray word before the verdict.
        for (n = 0; n < 100000 && board.outstanding() > 0; n++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/skle_pkg.sv
rtl/skle_cell.sv
rtl/sorted_key_list_engine_unit.sv
tb/sorted_key_list_engine_unit_tb.sv
